>>> design/tea16_pkg.sv
// shared types, constants and round functions of the tea16 block cipher
`timescale 1ns / 1ps
`default_nettype none

package tea16_pkg;

    // round constant and default number of cycles
    localparam logic [31:0] TEA_DELTA         = 32'h9E37_79B9;
    localparam int          CYCLE_COUNT_DEF   = 16;

    // kind codes
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    // one word in flight: block halves, key and kind
    typedef struct packed {
        logic        kind;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea16_word_t;

    // feistel mixing function of one half-round
    function automatic logic [31:0] mix_word(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        logic [31:0] shl;
        logic [31:0] shr;
        shl = v << 4;
        shr = v >> 5;
        return (shl + ka) ^ (v + sum) ^ (shr + kb);
    endfunction

    // running sum after count additions of the delta, modulo 2^32
    function automatic logic [31:0] tea_sum(input int count);
        logic [63:0] prod;
        prod = 64'(count) * 64'(TEA_DELTA);
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

>>> design/tea16_if.sv
// request and response channels of the tea16 block cipher
`timescale 1ns / 1ps
`default_nettype none

interface tea16_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] text_low;
    logic [31:0] text_high;
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;

    modport source (
        output valid, kind, text_low, text_high,
               key_word0, key_word1, key_word2, key_word3,
        input  ready
    );
    modport sink (
        input  valid, kind, text_low, text_high,
               key_word0, key_word1, key_word2, key_word3,
        output ready
    );
endinterface

interface tea16_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_low;
    logic [31:0] result_high;

    modport source (
        output valid, result_low, result_high,
        input  ready
    );
    modport sink (
        input  valid, result_low, result_high,
        output ready
    );
endinterface

`default_nettype wire

>>> design/tea16_stage.sv
// one pipeline stage: a single feistel half-round with its output register
`timescale 1ns / 1ps
`default_nettype none

module tea16_stage
    import tea16_pkg::*;
#(
    parameter int CYCLE_COUNT = CYCLE_COUNT_DEF,
    parameter int STAGE       = 0
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire tea16_word_t in_data,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      tea16_word_t out_data
);

    // sums seen by this half-round, encrypt counts up, decrypt counts down
    localparam int          CYCLE_IDX = STAGE / 2;
    localparam logic        ODD_HALF  = ((STAGE % 2) == 1) ? 1'b1 : 1'b0;
    localparam logic [31:0] ENC_SUM   = tea_sum(CYCLE_IDX + 1);
    localparam logic [31:0] DEC_SUM   = tea_sum(CYCLE_COUNT - CYCLE_IDX);

    logic        valid_reg;
    logic        valid_next;
    tea16_word_t data_reg;
    tea16_word_t data_next;
    logic        load;

    logic        upd_low;
    logic [31:0] sum;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] mix;
    logic [31:0] upd;

    // stage takes a word when empty or when its word moves on
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // half-round: encrypt updates v0 first, decrypt updates v1 first
    always_comb
    begin
        upd_low = (in_data.kind == ODD_HALF);
        sum     = (in_data.kind == KIND_DECRYPT) ? DEC_SUM : ENC_SUM;
        src     = upd_low ? in_data.v1 : in_data.v0;
        tgt     = upd_low ? in_data.v0 : in_data.v1;
        ka      = upd_low ? in_data.k0 : in_data.k2;
        kb      = upd_low ? in_data.k1 : in_data.k3;
        mix     = mix_word(src, sum, ka, kb);
        upd     = (in_data.kind == KIND_DECRYPT) ? (tgt - mix) : (tgt + mix);

        data_next = in_data;
        if (upd_low)
        begin
            data_next.v0 = upd;
        end
        else
        begin
            data_next.v1 = upd;
        end
    end

    // occupancy
    always_comb
    begin
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // a stalled word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
    else $error("tea16_stage: stalled word lost or changed");

    // an empty stage never blocks the one before it
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
    else $error("tea16_stage: empty stage not ready");

    // a taken word occupies the stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
    else $error("tea16_stage: taken word dropped");

endmodule

`default_nettype wire

>>> design/tea16_block_cipher.sv
// Block cipher with the tea round function, CYCLE_COUNT rounds of two half-rounds each
// and delta 0x9E3779B9; request kind 0 encrypts the 64-bit block, 1 decrypts it. The
// datapath is a chain of 2*CYCLE_COUNT register stages, one half-round per stage (one
// mixing function and one add or subtract), with the key and kind traveling alongside
// the block. A word can enter every cycle while the response is not stalled; the last
// stage register drives the response. Each stage has its own ready, so a stall on the
// response only holds the occupied stages and bubbles ahead of it keep filling; nothing
// is kept between words.
`timescale 1ns / 1ps
`default_nettype none

module tea16_block_cipher
    import tea16_pkg::*;
#(
    parameter int CYCLE_COUNT = CYCLE_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tea16_req_if.sink   request,
    tea16_rsp_if.source response
);

    localparam int STAGES = 2 * CYCLE_COUNT;

    // chain links: index i feeds stage i, index STAGES is the response
    logic        link_valid [STAGES+1];
    logic        link_ready [STAGES+1];
    tea16_word_t link_data  [STAGES+1];

    // pack the request word
    assign link_valid[0]   = request.valid;
    assign request.ready   = link_ready[0];
    assign link_data[0].kind = request.kind;
    assign link_data[0].v0 = request.text_low;
    assign link_data[0].v1 = request.text_high;
    assign link_data[0].k0 = request.key_word0;
    assign link_data[0].k1 = request.key_word1;
    assign link_data[0].k2 = request.key_word2;
    assign link_data[0].k3 = request.key_word3;

    // half-round stages
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        tea16_stage #(
            .CYCLE_COUNT (CYCLE_COUNT),
            .STAGE       (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // response word
    assign response.valid       = link_valid[STAGES];
    assign link_ready[STAGES]   = response.ready;
    assign response.result_low  = link_data[STAGES].v0;
    assign response.result_high = link_data[STAGES].v1;

endmodule

`default_nettype wire
